// ===== rtl/core/etf_pkg.sv =====
`default_nettype none

package etf_pkg;

   localparam int CNT_W   = 16;
   localparam int TS_W    = 24;
   localparam int PLEN_W  = CNT_W + 1;
   localparam int TYPE_W  = 3;
   localparam int ADDR_W  = 2;
   localparam int DATA_W  = 32;

   localparam logic [CNT_W-1:0]  IDLE_TOP_RESET     = 16'd62499;
   localparam int                RING_DEPTH_DEFAULT = 4;
   localparam logic [ADDR_W-1:0] ADDR_IDLE_TOP      = 2'd0;

   typedef enum logic [TYPE_W-1:0] {
      REQ_TICK       = 3'd0,
      REQ_CAPTURE    = 3'd1,
      REQ_READ_NOW   = 3'd2,
      REQ_POP_EDGE   = 3'd3,
      REQ_SET_PERIOD = 3'd4,
      REQ_OUTPUT_OFF = 3'd5
   } req_code_type;

   typedef struct packed {
      logic clr_out;
      logic set_base;
      logic set_out;
   } pend_flags_type;

   typedef struct packed {
      logic [TS_W-1:0] timestamp;
      logic            edge_available;
      logic            out_level;
      logic            out_enabled;
   } etf_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/etf_if.sv =====
`default_nettype none

interface etf_req_if;
   import etf_pkg::*;
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [CNT_W-1:0]  period_top;

   modport source (output valid, output req_type, output period_top, input ready);
   modport sink   (input valid, input req_type, input period_top, output ready);
endinterface

interface etf_rsp_if;
   import etf_pkg::*;
   logic            valid;
   logic            ready;
   logic [TS_W-1:0] timestamp;
   logic            edge_available;
   logic            out_level;
   logic            out_enabled;

   modport source (output valid, output timestamp, output edge_available,
                   output out_level, output out_enabled, input ready);
   modport sink   (input valid, input timestamp, input edge_available,
                   input out_level, input out_enabled, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/edge_timestamp_and_frequency_output.sv =====
// A request accepted at one clock edge has its response valid after that edge.
// A two-entry response buffer keeps requests flowing while a response waits.
// Throughput: one request per cycle unless that buffer is full; the timer state updates
// in a single pass. Reset (synchronous, active high) clears the timer, flags, ring
// indexes and buffer; idle_top returns to 62499. Edge ring contents are not cleared.
`default_nettype none

module edge_timestamp_and_frequency_output #(
   parameter int RING_DEPTH = etf_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   etf_req_if.sink                         req_chan,
   etf_rsp_if.source                       rsp_chan,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [etf_pkg::ADDR_W-1:0] paddr,
   input  wire logic [etf_pkg::DATA_W-1:0] pwdata,
   output logic [etf_pkg::DATA_W-1:0]      prdata,
   output logic                            pready
);
   import etf_pkg::*;

   logic [CNT_W-1:0] idle_top_ff, idle_top_in;
   logic             csr_write;
   logic             accept;
   logic             buf_full;
   logic             buf_valid;
   etf_result_type   core_result;
   etf_result_type   buf_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr == ADDR_IDLE_TOP) ? DATA_W'(idle_top_ff) : '0;

   always_comb begin
      idle_top_in = idle_top_ff;
      if (csr_write && (paddr == ADDR_IDLE_TOP)) begin
         idle_top_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_top_ff <= IDLE_TOP_RESET;
      end else begin
         idle_top_ff <= idle_top_in;
      end
   end

   assign req_chan.ready = !buf_full;
   assign accept         = req_chan.valid && !buf_full;

   etf_timer_core #(
      .RING_DEPTH (RING_DEPTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_type   (req_chan.req_type),
      .period_top (req_chan.period_top),
      .idle_top   (idle_top_ff),
      .result     (core_result)
   );

   etf_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .pop       (rsp_chan.ready),
      .full      (buf_full),
      .valid     (buf_valid),
      .head      (buf_head)
   );

   assign rsp_chan.valid          = buf_valid;
   assign rsp_chan.timestamp      = buf_head.timestamp;
   assign rsp_chan.edge_available = buf_head.edge_available;
   assign rsp_chan.out_level      = buf_head.out_level;
   assign rsp_chan.out_enabled    = buf_head.out_enabled;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_chan.valid)
      else $error("accepted request produced no response");

   a_full_has_rsp: assert property (@(posedge clock) disable iff (reset)
      buf_full |-> buf_valid)
      else $error("response buffer full but shows nothing");

   a_no_pop_empty_ts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.req_type == REQ_TICK)) |=> (core_result.timestamp == '0)
         || !accept || (req_chan.req_type != REQ_TICK))
      else $error("tick request produced a timestamp");

endmodule

`default_nettype wire

// ===== rtl/core/etf_timer_core.sv =====
`default_nettype none

module etf_timer_core #(
   parameter int RING_DEPTH = etf_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [etf_pkg::TYPE_W-1:0]    req_type,
   input  wire logic [etf_pkg::CNT_W-1:0]     period_top,
   input  wire logic [etf_pkg::CNT_W-1:0]     idle_top,
   output etf_pkg::etf_result_type            result
);
   import etf_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      next_idx = (i == IDX_LAST) ? '0 : i + IDX_W'(1);
   endfunction

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  active_top_ff, active_top_in;
   logic [CNT_W-1:0]  top_buffer_ff, top_buffer_in;
   logic [TS_W-1:0]   tbase_ff, tbase_in;
   logic [PLEN_W-1:0] period_length_ff, period_length_in;
   logic [CNT_W-1:0]  pending_top_ff, pending_top_in;
   pend_flags_type    flags_ff, flags_in;
   logic              toggle_ff, toggle_in;
   logic              pin_ff, pin_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [TS_W-1:0]   head_ff;
   logic [TS_W-1:0]   ring_mem [RING_DEPTH];

   logic [TS_W-1:0]   now_time;
   logic [TS_W-1:0]   ts;
   logic              ring_we;

   assign now_time = tbase_ff + TS_W'(count_ff);

   always_comb begin
      count_in         = count_ff;
      active_top_in    = active_top_ff;
      top_buffer_in    = top_buffer_ff;
      tbase_in         = tbase_ff;
      period_length_in = period_length_ff;
      pending_top_in   = pending_top_ff;
      flags_in         = flags_ff;
      toggle_in        = toggle_ff;
      pin_in           = pin_ff;
      rd_idx_in        = rd_idx_ff;
      wr_idx_in        = wr_idx_ff;
      ts               = '0;
      ring_we          = 1'b0;
      if (accept) begin
         case (req_code_type'(req_type))
            REQ_TICK: begin
               if (count_ff == active_top_ff) begin
                  count_in      = '0;
                  active_top_in = top_buffer_ff;
                  pin_in        = pin_ff ^ toggle_ff;
                  tbase_in      = tbase_ff + TS_W'(period_length_ff);
                  if (flags_ff.set_base) begin
                     period_length_in  = PLEN_W'(top_buffer_ff) + PLEN_W'(1);
                     flags_in.set_base = 1'b0;
                  end
                  if (flags_ff.set_out) begin
                     if (!flags_ff.clr_out) begin
                        toggle_in = 1'b1;
                     end
                     top_buffer_in     = pending_top_ff;
                     flags_in.set_out  = 1'b0;
                     flags_in.set_base = 1'b1;
                  end
                  // output is switched off only once the pin sits low
                  if (flags_ff.clr_out && !pin_in) begin
                     toggle_in        = 1'b0;
                     flags_in.clr_out = 1'b0;
                  end
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_CAPTURE: begin
               ring_we   = 1'b1;
               wr_idx_in = next_idx(wr_idx_ff);
            end
            REQ_READ_NOW: begin
               ts = now_time;
            end
            REQ_POP_EDGE: begin
               if (rd_idx_ff != wr_idx_ff) begin
                  ts        = head_ff;
                  rd_idx_in = next_idx(rd_idx_ff);
               end
            end
            REQ_SET_PERIOD: begin
               pending_top_in   = period_top;
               flags_in.set_out = 1'b1;
            end
            REQ_OUTPUT_OFF: begin
               pending_top_in   = idle_top;
               flags_in.set_out = 1'b1;
               flags_in.clr_out = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.timestamp      = ts;
      result.edge_available = (rd_idx_in != wr_idx_in);
      result.out_level      = pin_in;
      result.out_enabled    = toggle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         active_top_ff    <= IDLE_TOP_RESET;
         top_buffer_ff    <= IDLE_TOP_RESET;
         tbase_ff         <= '0;
         period_length_ff <= PLEN_W'(IDLE_TOP_RESET) + PLEN_W'(1);
         pending_top_ff   <= '0;
         flags_ff         <= '0;
         toggle_ff        <= 1'b0;
         pin_ff           <= 1'b0;
         rd_idx_ff        <= '0;
         wr_idx_ff        <= '0;
      end else begin
         count_ff         <= count_in;
         active_top_ff    <= active_top_in;
         top_buffer_ff    <= top_buffer_in;
         tbase_ff         <= tbase_in;
         period_length_ff <= period_length_in;
         pending_top_ff   <= pending_top_in;
         flags_ff         <= flags_in;
         toggle_ff        <= toggle_in;
         pin_ff           <= pin_in;
         rd_idx_ff        <= rd_idx_in;
         wr_idx_ff        <= wr_idx_in;
      end
   end

   // head_ff always holds the entry at the read index, with write bypass
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wr_idx_ff] <= now_time;
      end
      if (ring_we && (wr_idx_ff == rd_idx_in)) begin
         head_ff <= now_time;
      end else begin
         head_ff <= ring_mem[rd_idx_in];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/etf_rsp_buf.sv =====
`default_nettype none

module etf_rsp_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire etf_pkg::etf_result_type push_data,
   input  wire logic                    pop,
   output logic                         full,
   output logic                         valid,
   output etf_pkg::etf_result_type      head
);
   import etf_pkg::*;

   etf_result_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     fill_ff, fill_in;
   logic           do_pop;

   assign valid  = (fill_ff != 2'd0);
   assign full   = (fill_ff == 2'd2);
   assign head   = slot_ff[rd_ptr_ff];
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/etf_timestamp_checker.sv =====
`timescale 1ns / 100ps

module etf_timestamp_checker #(
   parameter int RING_DEPTH = etf_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   etf_req_if                              req_mon,
   etf_rsp_if                              rsp_mon,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic                       pready,
   input  wire logic [etf_pkg::ADDR_W-1:0] paddr,
   input  wire logic [etf_pkg::DATA_W-1:0] pwdata,
   output int                              outstanding,
   output int                              mismatches
);
   import etf_pkg::*;

   logic [CNT_W-1:0]  idle_top;
   logic [CNT_W-1:0]  count;
   logic [CNT_W-1:0]  active_top;
   logic [CNT_W-1:0]  top_buffer;
   logic [CNT_W-1:0]  pending_top;
   logic [TS_W-1:0]   tbase;
   logic [PLEN_W-1:0] period_len;
   pend_flags_type    pend;
   logic              toggle_en;
   logic              pin;
   logic [TS_W-1:0]   edge_ring [RING_DEPTH];
   int                rd_idx;
   int                wr_idx;

   etf_result_type    due_responses[$];
   int                pending_cnt = 0;
   int                err_count = 0;

   assign outstanding = pending_cnt;
   assign mismatches  = err_count;

   function automatic int ring_next(int i);
      return (i + 1 == RING_DEPTH) ? 0 : i + 1;
   endfunction

   function automatic logic [TS_W-1:0] now_time();
      return tbase + TS_W'(count);
   endfunction

   task automatic advance_timer(input logic [TYPE_W-1:0] kind,
                                input logic [CNT_W-1:0] new_top,
                                output etf_result_type res);
      logic [TS_W-1:0] stamp;
      stamp = '0;
      case (kind)
         REQ_TICK: begin
            if (count == active_top) begin
               // period end: order of the steps matters
               count = '0;
               active_top = top_buffer;
               if (toggle_en) pin = ~pin;
               tbase = tbase + TS_W'(period_len);
               if (pend.set_base) begin
                  period_len = PLEN_W'(top_buffer) + PLEN_W'(1);
                  pend.set_base = 1'b0;
               end
               if (pend.set_out) begin
                  if (!pend.clr_out) toggle_en = 1'b1;
                  top_buffer = pending_top;
                  pend.set_out = 1'b0;
                  pend.set_base = 1'b1;
               end
               if (pend.clr_out && !pin) begin
                  toggle_en = 1'b0;
                  pend.clr_out = 1'b0;
               end
            end else begin
               count = count + CNT_W'(1);
            end
         end
         REQ_CAPTURE: begin
            // overwrites on overflow; meeting rd_idx empties the ring
            edge_ring[wr_idx] = now_time();
            wr_idx = ring_next(wr_idx);
         end
         REQ_READ_NOW: stamp = now_time();
         REQ_POP_EDGE: begin
            if (rd_idx != wr_idx) begin
               stamp = edge_ring[rd_idx];
               rd_idx = ring_next(rd_idx);
            end
         end
         REQ_SET_PERIOD: begin
            pending_top = new_top;
            pend.set_out = 1'b1;
         end
         REQ_OUTPUT_OFF: begin
            pending_top = idle_top;
            pend.set_out = 1'b1;
            pend.clr_out = 1'b1;
         end
         default: ;
      endcase
      res.timestamp      = stamp;
      res.edge_available = (rd_idx != wr_idx);
      res.out_level      = pin;
      res.out_enabled    = toggle_en;
   endtask

   always @(posedge clock) begin : watch
      etf_result_type got;
      etf_result_type want;
      if (reset) begin
         idle_top    = IDLE_TOP_RESET;
         count       = '0;
         active_top  = IDLE_TOP_RESET;
         top_buffer  = IDLE_TOP_RESET;
         pending_top = '0;
         tbase       = '0;
         period_len  = PLEN_W'(IDLE_TOP_RESET) + PLEN_W'(1);
         pend        = '0;
         toggle_en   = 1'b0;
         pin         = 1'b0;
         rd_idx      = 0;
         wr_idx      = 0;
         for (int i = 0; i < RING_DEPTH; i++) edge_ring[i] = '0;
         due_responses.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_IDLE_TOP)
            idle_top = pwdata[CNT_W-1:0];

         // a response leaving at this edge always belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.timestamp      = rsp_mon.timestamp;
            got.edge_available = rsp_mon.edge_available;
            got.out_level      = rsp_mon.out_level;
            got.out_enabled    = rsp_mon.out_enabled;
            if (due_responses.size() == 0) begin
               $error("response with no request outstanding: timestamp %0d",
                      got.timestamp);
               err_count++;
            end else begin
               want = due_responses.pop_front();
               if (got.timestamp !== want.timestamp) begin
                  $error("timestamp: expected %0d, got %0d", want.timestamp, got.timestamp);
                  err_count++;
               end
               if (got.edge_available !== want.edge_available) begin
                  $error("edge_available: expected %0d, got %0d",
                         want.edge_available, got.edge_available);
                  err_count++;
               end
               if (got.out_level !== want.out_level) begin
                  $error("out_level: expected %0d, got %0d", want.out_level, got.out_level);
                  err_count++;
               end
               if (got.out_enabled !== want.out_enabled) begin
                  $error("out_enabled: expected %0d, got %0d",
                         want.out_enabled, got.out_enabled);
                  err_count++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            advance_timer(req_mon.req_type, req_mon.period_top, want);
            due_responses.push_back(want);
         end
      end
      pending_cnt = due_responses.size();
   end

endmodule

// ===== tb/sv/tb_edge_timestamp_and_frequency_output.sv =====
`timescale 1ns / 100ps

module tb_edge_timestamp_and_frequency_output;
   import etf_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 300;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int outstanding;
   int mismatches;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;

   etf_req_if req_bus ();
   etf_rsp_if rsp_bus ();

   edge_timestamp_and_frequency_output #(
      .RING_DEPTH(RING_DEPTH_DEFAULT)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   etf_timestamp_checker #(
      .RING_DEPTH(RING_DEPTH_DEFAULT)
   ) timer_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_span();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : receiver
      rsp_bus.ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat (idle_span()) @(negedge clock);
         end
      end
   end

   task automatic send_request(req_code_type kind, logic [CNT_W-1:0] top);
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.period_top <= top;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle_span()) @(negedge clock);
      end
   endtask

   task automatic send_random();
      int               pick = $urandom_range(0, 99);
      logic [CNT_W-1:0] top = CNT_W'($urandom);
      req_code_type     kind;
      if (pick < 50)      kind = REQ_TICK;
      else if (pick < 63) kind = REQ_CAPTURE;
      else if (pick < 73) kind = REQ_READ_NOW;
      else if (pick < 87) kind = REQ_POP_EDGE;
      else if (pick < 95) kind = REQ_SET_PERIOD;
      else                kind = REQ_OUTPUT_OFF;
      // short periods keep period ends frequent
      if (kind == REQ_SET_PERIOD) top = CNT_W'($urandom_range(0, 6));
      send_request(kind, top);
   endtask

   // only while idle: every request answered
   task automatic write_idle_top(logic [CNT_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_IDLE_TOP;
      pwdata  <= DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CNT_W-1:0] phase_top [4];
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_TICK;
      req_bus.period_top <= '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty ring, overflow back to empty, then one live entry
      send_request(REQ_READ_NOW, 16'h0000);
      send_request(REQ_POP_EDGE, 16'hFFFF);
      repeat (5) send_request(REQ_CAPTURE, 16'h0000);
      send_request(REQ_POP_EDGE, 16'h0000);
      send_request(REQ_POP_EDGE, 16'h0000);
      send_request(REQ_TICK, 16'hFFFF);
      send_request(REQ_TICK, 16'h0000);
      send_request(REQ_READ_NOW, 16'h0000);
      send_request(REQ_SET_PERIOD, 16'hFFFF);
      send_request(REQ_SET_PERIOD, 16'h0000);
      send_request(REQ_OUTPUT_OFF, 16'hFFFF);
      send_request(REQ_CAPTURE, 16'h0000);
      send_request(REQ_READ_NOW, 16'h0000);

      phase_top[0] = 16'd2;
      phase_top[1] = CNT_W'($urandom_range(0, 15));
      phase_top[2] = 16'd0;
      phase_top[3] = 16'hFFFF;
      for (int p = 0; p < 4; p++) begin
         write_idle_top(phase_top[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 0 && n == 100) begin
               // receiver stalls, sender keeps offering until the block backs up
               quiet = 1'b1;
               hold_request = 1'b1;
               repeat (20) send_random();
               quiet = 1'b0;
            end
            send_random();
         end
      end

      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
